// File: src/letter_only_line_sorter_core_assert.svh
// Assertion macros for the letter-only line sorter
`ifndef LETTER_ONLY_LINE_SORTER_CORE_ASSERT_SVH
`define LETTER_ONLY_LINE_SORTER_CORE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define LOLS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication
`define LOLS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// File: src/lols_pkg.sv
// Package for the letter-only line sorter: sizes and the key letter function
package lols_pkg;
    localparam int MAX_LINES_DEF      = 64;
    localparam int MAX_LINE_CHARS_DEF = 64;
    localparam int STORE_BYTES_DEF    = 4096;
    localparam logic [7:0] CHAR_NL    = 8'd10;

    // letter in lower case, bit 8 set when the byte is a letter
    function automatic logic [8:0] key_letter(input logic [7:0] c);
        logic [8:0] r;
        r = 9'd0;
        if (c >= 8'h41 && c <= 8'h5a) r = {1'b1, c + 8'h20};
        else if (c >= 8'h61 && c <= 8'h7a) r = {1'b1, c};
        return r;
    endfunction
endpackage

// File: src/letter_only_line_sorter_core.sv
// Top level of the letter-only line sorter: byte loader, insertion sort and emitter
//
// Usage:
//  s_axis carries text bytes: tdata[7:0] the byte, tuser[0] end of text.
//  Bytes are taken one per cycle while loading. A newline or end of text
//  closes a line; empty lines are dropped. On end of text s_axis_tready
//  falls and an insertion sort runs over the stored lines. Each key
//  comparison walks both lines through the single store_mem read port,
//  one stored byte read at a time (one read per line in turn), so a sort
//  takes on the order of n^2/4 comparisons.
//  m_axis then emits one beat per line: tdata[5:0] line index,
//  tuser[0] is_last, [1] no_lines, [2] overflow. A text with no line gives
//  one beat with no_lines set. The emitter holds its beat while
//  m_axis_tready is low; loading resumes after the last beat is taken.
//  cfg_valid/cfg_ready write reverse_order (cfg_data[0]) while idle.
//  Reset (aresetn low, synchronous) clears counters and the sequencer;
//  the stores hold undefined data until written.
module letter_only_line_sorter_core
    import lols_pkg::*;
#(
    parameter int MAX_LINES      = MAX_LINES_DEF,
    parameter int MAX_LINE_CHARS = MAX_LINE_CHARS_DEF,
    parameter int STORE_BYTES    = STORE_BYTES_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic [0:0] s_axis_tuser,   // [0] end_of_text
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [5:0] line_index, [7:6] zero
    output logic [2:0] m_axis_tuser,   // [0] is_last, [1] no_lines, [2] overflow
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [0:0] cfg_data        // [0] reverse_order
);
`include "letter_only_line_sorter_core_assert.svh"
    localparam int LW = $clog2(MAX_LINES);
    localparam int CW = $clog2(MAX_LINES + 1);
    localparam int AW = $clog2(STORE_BYTES);
    localparam int PW = $clog2(STORE_BYTES + 1);
    localparam int LLW = $clog2(MAX_LINE_CHARS + 1);

    localparam logic [3:0] S_LOAD = 4'd0, S_OUTER = 4'd1, S_CMP = 4'd2,
        S_RDA = 4'd3, S_WA = 4'd4, S_RDB = 4'd5, S_WB = 4'd6, S_DEC = 4'd7,
        S_EMIT = 4'd8, S_PLACE = 4'd9, S_SHIFT = 4'd10, S_ERD = 4'd11;

    logic [3:0]     state_reg;
    logic [7:0]     store_mem [STORE_BYTES];
    logic [AW-1:0]  start_mem [MAX_LINES];
    logic [LLW-1:0] len_mem   [MAX_LINES];
    logic [LW-1:0]  ord_mem   [MAX_LINES];
    logic [CW-1:0]  count_reg;
    logic [LLW-1:0] cur_len_reg;
    logic [PW-1:0]  wptr_reg;
    logic           ovf_reg, rev_reg;
    logic [CW-1:0]  i_reg, j_reg;
    logic [AW-1:0]  sa_reg, sb_reg;
    logic [LLW-1:0] la_reg, lb_reg, pa_reg, pb_reg;
    logic [8:0]     ka_reg;
    logic [7:0]     rd_reg;
    logic [AW-1:0]  rd_addr;
    logic [LW-1:0]  ord_rd_reg;
    logic           out_valid_reg, out_last_reg, out_none_reg;
    logic [LW-1:0]  out_idx_reg;
    logic [8:0]     kb;
    logic           take, stor, close;

    assign s_axis_tready = (state_reg == S_LOAD);
    assign cfg_ready     = (state_reg == S_LOAD);
    assign take  = s_axis_tvalid && s_axis_tready;
    assign close = take && (s_axis_tdata == CHAR_NL || s_axis_tuser[0]);
    assign stor  = take && s_axis_tdata != CHAR_NL && count_reg < CW'(MAX_LINES)
        && cur_len_reg < LLW'(MAX_LINE_CHARS) && wptr_reg < PW'(STORE_BYTES);

    // read address of the current key position on line a or b
    always_comb begin
        if (state_reg == S_RDA)
            rd_addr = sa_reg + AW'(rev_reg ? la_reg - 1'b1 - pa_reg : pa_reg);
        else
            rd_addr = sb_reg + AW'(rev_reg ? lb_reg - 1'b1 - pb_reg : pb_reg);
    end
    assign kb = key_letter(rd_reg);

    always_ff @(posedge aclk) begin
        rd_reg <= store_mem[rd_addr];
        ord_rd_reg <= ord_mem[j_reg[LW-1:0] - 1'b1];
        if (stor) store_mem[wptr_reg[AW-1:0]] <= s_axis_tdata;
        if (close && count_reg < CW'(MAX_LINES) && (cur_len_reg != 0 || stor)) begin
            start_mem[count_reg[LW-1:0]] <= AW'(wptr_reg - PW'(cur_len_reg));
            len_mem[count_reg[LW-1:0]] <= cur_len_reg + LLW'(stor);
        end
        if (state_reg == S_SHIFT) ord_mem[j_reg[LW-1:0]] <= ord_rd_reg;
        if (state_reg == S_PLACE) ord_mem[j_reg[LW-1:0]] <= i_reg[LW-1:0];
        if (state_reg == S_OUTER) begin
            sb_reg <= start_mem[i_reg[LW-1:0]];
            lb_reg <= len_mem[i_reg[LW-1:0]];
        end
        if (state_reg == S_CMP) begin
            sa_reg <= start_mem[ord_rd_reg];
            la_reg <= len_mem[ord_rd_reg];
        end
        // ord[j-1] has settled in ord_rd_reg by the first emit cycle
        if (state_reg == S_EMIT && !out_valid_reg) out_idx_reg <= ord_rd_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_LOAD; count_reg <= '0; cur_len_reg <= '0; wptr_reg <= '0;
            ovf_reg <= 1'b0; rev_reg <= 1'b0; out_valid_reg <= 1'b0;
            i_reg <= '0; j_reg <= '0; pa_reg <= '0; pb_reg <= '0; ka_reg <= '0;
            out_last_reg <= 1'b0; out_none_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_LOAD: begin
                    if (cfg_valid) rev_reg <= cfg_data[0];
                    if (take) begin
                        if (s_axis_tdata != CHAR_NL && !stor) ovf_reg <= 1'b1;
                        if (stor) begin
                            wptr_reg <= wptr_reg + 1'b1;
                            cur_len_reg <= cur_len_reg + 1'b1;
                        end
                        if (close) begin
                            cur_len_reg <= '0;
                            if (count_reg < CW'(MAX_LINES) && (cur_len_reg != 0 || stor))
                                count_reg <= count_reg + 1'b1;
                        end
                        if (s_axis_tuser[0]) begin
                            i_reg <= '0;
                            state_reg <= S_OUTER;
                        end
                    end
                end
                S_OUTER: begin
                    if (i_reg == count_reg) begin
                        i_reg <= '0;
                        j_reg <= CW'(1);
                        state_reg <= S_ERD;
                    end else begin
                        j_reg <= i_reg;
                        state_reg <= S_DEC;
                    end
                end
                S_DEC: begin
                    // ord[j-1] reaches ord_rd_reg during S_CMP
                    pa_reg <= '0; pb_reg <= '0;
                    state_reg <= (j_reg == 0) ? S_PLACE : S_CMP;
                end
                S_CMP: state_reg <= S_RDA;
                S_RDA: begin
                    if (pa_reg == la_reg) state_reg <= S_PLACE; // key a ended: not after
                    else state_reg <= S_WA;
                end
                S_WA: begin
                    pa_reg <= pa_reg + 1'b1;
                    state_reg <= S_RDA;
                    if (kb[8]) begin
                        ka_reg <= kb;
                        state_reg <= S_RDB;
                    end
                end
                S_RDB: begin
                    if (pb_reg == lb_reg) state_reg <= S_SHIFT; // key b ended first
                    else state_reg <= S_WB;
                end
                S_WB: begin
                    pb_reg <= pb_reg + 1'b1;
                    state_reg <= S_RDB;
                    if (kb[8]) begin
                        if (kb == ka_reg) state_reg <= S_RDA;
                        else state_reg <= (ka_reg > kb) ? S_SHIFT : S_PLACE;
                    end
                end
                S_SHIFT: begin
                    j_reg <= j_reg - 1'b1;
                    state_reg <= S_DEC;
                end
                S_PLACE: begin
                    i_reg <= i_reg + 1'b1;
                    j_reg <= i_reg + 1'b1;
                    state_reg <= S_OUTER;
                end
                S_ERD: state_reg <= S_EMIT;
                S_EMIT: begin
                    if (!out_valid_reg) begin
                        out_valid_reg <= 1'b1;
                        out_none_reg <= (count_reg == 0);
                        out_last_reg <= (count_reg == 0) || (j_reg == count_reg);
                    end else if (m_axis_tready) begin
                        out_valid_reg <= 1'b0;
                        if (out_last_reg) begin
                            count_reg <= '0; cur_len_reg <= '0; wptr_reg <= '0;
                            ovf_reg <= 1'b0; state_reg <= S_LOAD;
                        end else begin
                            j_reg <= j_reg + 1'b1;
                            state_reg <= S_ERD;
                        end
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, 6'(out_none_reg ? '0 : out_idx_reg)};
    assign m_axis_tuser  = {ovf_reg, out_none_reg, out_last_reg};

    `LOLS_ASSERT_IMPL(a_ready_only_load, aclk, aresetn, s_axis_tready, !m_axis_tvalid)
    `LOLS_ASSERT_NEXT(a_hold_out, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    `LOLS_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CW'(MAX_LINES))
endmodule

// File: tb/sv/tb_letter_only_line_sorter_core.sv
// Testbench for the letter-only line sorter: table-driven and random texts against a predictor
`timescale 1ns / 100ps

module tb_letter_only_line_sorter_core;
    import lols_pkg::*;

    typedef struct packed {
        logic [5:0] idx;
        logic       last;
        logic       nol;
        logic       ovf;
    } sorted_beat_t;

    // row: {typed, ovf, no_lines, is_last, line_index[5:0], end_of_text, byte[7:0]}
    localparam int N_ROWS = 18;
    localparam logic [18:0] DIR_ROWS [0:N_ROWS-1] = '{
        {1'b1, 1'b0, 1'b1, 1'b1, 6'd0, 1'b1, 8'd10},
        {1'b1, 1'b0, 1'b0, 1'b1, 6'd0, 1'b1, 8'h7a},
        {1'b1, 1'b0, 1'b0, 1'b1, 6'd0, 1'b1, 8'h00},
        {1'b1, 1'b0, 1'b0, 1'b1, 6'd0, 1'b1, 8'hff},
        {1'b1, 1'b0, 1'b0, 1'b1, 6'd0, 1'b1, 8'h39},
        {1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0, 8'h42},
        {1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0, 8'h61},
        {1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0, 8'd10},
        {1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0, 8'h61},
        {1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0, 8'h31},
        {1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0, 8'h62},
        {1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0, 8'd10},
        {1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0, 8'd10},
        {1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0, 8'h41},
        {1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0, 8'd10},
        {1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0, 8'h5a},
        {1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b0, 8'h40},
        {1'b0, 1'b0, 1'b0, 1'b0, 6'd0, 1'b1, 8'h41}
    };

    logic       aclk;
    logic       aresetn;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic [0:0] s_axis_tuser;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;
    logic [2:0] m_axis_tuser;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [0:0] cfg_data;

    letter_only_line_sorter_core uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    // predictor state
    logic [7:0] text_mem [0:STORE_BYTES_DEF-1];
    int         start_of [0:MAX_LINES_DEF-1];
    int         len_of [0:MAX_LINES_DEF-1];
    int         order_of [0:MAX_LINES_DEF-1];
    int         n_lines, cur_len, wr_ptr;
    bit         dropped, backward;

    sorted_beat_t sorted_q [$];
    sorted_beat_t scratch_q [$];

    int errors, beats_seen, bytes_sent, texts_sent, idle_mode;
    bit rev_written [0:1];

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    function automatic int key_char(int line, ref int pos);
        int off, addr;
        logic [8:0] k;
        while (pos < len_of[line]) begin
            off = backward ? (len_of[line] - 1 - pos) : pos;
            addr = start_of[line] + off;
            pos++;
            if (addr < STORE_BYTES_DEF) begin
                k = 9'd0;
                if (text_mem[addr] >= "A" && text_mem[addr] <= "Z")
                    k = {1'b1, text_mem[addr] + 8'h20};
                else if (text_mem[addr] >= "a" && text_mem[addr] <= "z")
                    k = {1'b1, text_mem[addr]};
                if (k[8]) return int'(k[7:0]);
            end
        end
        return -1;
    endfunction

    function automatic bit sorts_after(int a, int b);
        int pa, pb, ca, cb;
        pa = 0;
        pb = 0;
        forever begin
            ca = key_char(a, pa);
            cb = key_char(b, pb);
            if (ca < 0) return 1'b0;
            if (cb < 0) return 1'b1;
            if (ca != cb) return ca > cb;
        end
    endfunction

    function automatic void close_line();
        if (cur_len != 0 && n_lines < MAX_LINES_DEF) begin
            start_of[n_lines] = wr_ptr - cur_len;
            len_of[n_lines] = cur_len;
            n_lines++;
        end
        cur_len = 0;
    endfunction

    // fold one accepted byte into the predictor; push the sorted run on end of text
    function automatic void predict_sort(logic [7:0] c, logic eot, ref sorted_beat_t q [$]);
        int i, j;
        sorted_beat_t b;
        if (c == CHAR_NL) begin
            close_line();
        end else begin
            if (n_lines >= MAX_LINES_DEF || cur_len >= MAX_LINE_CHARS_DEF ||
                wr_ptr >= STORE_BYTES_DEF) begin
                dropped = 1'b1;
            end else begin
                text_mem[wr_ptr] = c;
                wr_ptr++;
                cur_len++;
            end
            if (eot) close_line();
        end
        if (!eot) return;
        for (i = 0; i < n_lines; i++) begin
            j = i;
            while (j > 0 && sorts_after(order_of[j-1], i)) begin
                order_of[j] = order_of[j-1];
                j--;
            end
            order_of[j] = i;
        end
        if (n_lines == 0) begin
            b = '{idx: 6'd0, last: 1'b1, nol: 1'b1, ovf: dropped};
            q.push_back(b);
        end
        for (i = 0; i < n_lines; i++) begin
            b = '{idx: order_of[i][5:0], last: (i + 1 == n_lines), nol: 1'b0, ovf: dropped};
            q.push_back(b);
        end
        n_lines = 0;
        cur_len = 0;
        wr_ptr = 0;
        dropped = 1'b0;
    endfunction

    function automatic bit sender_idles();
        case (idle_mode)
            0: return $urandom_range(0, 99) < 18;
            1: return $urandom_range(0, 99) < 71;
            default: return 1'b0;
        endcase
    endfunction

    // receiver: check each beat, then pick the next ready level
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                beats_seen++;
                if (sorted_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected beat tdata=%h tuser=%b", $time,
                             m_axis_tdata, m_axis_tuser);
                end else begin
                    if (m_axis_tdata !== {2'b00, sorted_q[0].idx} ||
                        m_axis_tuser !== {sorted_q[0].ovf, sorted_q[0].nol, sorted_q[0].last}) begin
                        errors++;
                        $display("%0t: mismatch expected tdata=%h tuser=%b, got tdata=%h tuser=%b",
                                 $time, {2'b00, sorted_q[0].idx},
                                 {sorted_q[0].ovf, sorted_q[0].nol, sorted_q[0].last},
                                 m_axis_tdata, m_axis_tuser);
                    end
                    void'(sorted_q.pop_front());
                end
            end
            case (idle_mode)
                0: m_axis_tready <= $urandom_range(0, 99) >= 71;
                1: m_axis_tready <= $urandom_range(0, 99) >= 18;
                default: m_axis_tready <= 1'b1;
            endcase
        end
    end

    task automatic send_byte(logic [7:0] c, logic eot, bit typed, sorted_beat_t want);
        if (sender_idles()) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge aclk); while (sender_idles());
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        s_axis_tuser <= eot;
        do @(posedge aclk); while (!s_axis_tready);
        bytes_sent++;
        if (typed) begin
            predict_sort(c, eot, scratch_q);
            scratch_q.delete();
            sorted_q.push_back(want);
        end else begin
            predict_sort(c, eot, sorted_q);
        end
        if (eot) texts_sent++;
    endtask

    task automatic plain_byte(logic [7:0] c, logic eot);
        send_byte(c, eot, 1'b0, '0);
    endtask

    // hold until the run is out, then write the direction register
    task automatic set_direction(bit dir);
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (sorted_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= dir;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        backward = dir;
        rev_written[dir] = 1'b1;
    endtask

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 8'(8'h61 + $urandom_range(0, 2));
        if (r < 65) return 8'(8'h41 + $urandom_range(0, 2));
        if (r < 75) return 8'(8'h61 + $urandom_range(0, 25));
        if (r < 80) return 8'(8'h41 + $urandom_range(0, 25));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic random_text(int max_lines, int max_len);
        int nl, len, i, k;
        nl = $urandom_range(0, max_lines);
        for (i = 0; i < nl; i++) begin
            len = $urandom_range(0, max_len);
            for (k = 0; k < len; k++) plain_byte(pick_char(), 1'b0);
            if (i + 1 < nl || $urandom_range(0, 1)) plain_byte(CHAR_NL, 1'b0);
        end
        if ($urandom_range(0, 1)) plain_byte(CHAR_NL, 1'b1);
        else plain_byte(pick_char(), 1'b1);
    endtask

    initial begin
        int r;
        logic [18:0] row;
        sorted_beat_t want;
        errors = 0;
        beats_seen = 0;
        bytes_sent = 0;
        texts_sent = 0;
        idle_mode = 0;
        rev_written[0] = 1'b0;
        rev_written[1] = 1'b0;
        n_lines = 0;
        cur_len = 0;
        wr_ptr = 0;
        dropped = 1'b0;
        backward = 1'b0;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'd0;
        s_axis_tuser = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (r = 0; r < N_ROWS; r++) begin
            row = DIR_ROWS[r];
            want = '{idx: row[14:9], last: row[15], nol: row[16], ovf: row[17]};
            send_byte(row[7:0], row[8], row[18], want);
        end
        set_direction(1'b1);
        for (r = 9; r < N_ROWS; r++) plain_byte(DIR_ROWS[r][7:0], DIR_ROWS[r][8]);
        set_direction(1'b0);

        while (bytes_sent < 230) begin
            idle_mode = bytes_sent < 100 ? 0 : (bytes_sent < 170 ? 1 : 2);
            if ($urandom_range(0, 3) == 0) set_direction(1'($urandom_range(0, 1)));
            r = $urandom_range(0, 9);
            if (r < 7) begin
                random_text(6, 8);
            end else if (r < 9) begin
                repeat ($urandom_range(1, 12)) plain_byte(8'($urandom_range(0, 255)), 1'b0);
                plain_byte(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                random_text(2, 70);
            end
        end

        // overflow: one line too long, then more lines than the store holds
        set_direction(1'b1);
        repeat (70) plain_byte(8'(8'h61 + $urandom_range(0, 25)), 1'b0);
        plain_byte(CHAR_NL, 1'b0);
        repeat (65) begin
            plain_byte(8'(8'h61 + $urandom_range(0, 2)), 1'b0);
            plain_byte(CHAR_NL, 1'b0);
        end
        plain_byte(8'h62, 1'b1);
        set_direction(1'b0);
        random_text(3, 5);

        s_axis_tvalid <= 1'b0;
        while (sorted_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("%0d bytes in %0d texts, %0d sorted beats checked", bytes_sent, texts_sent,
                 beats_seen);
        $display("both key directions used: %0d, idle patterns: sender, receiver, none",
                 rev_written[0] && rev_written[1]);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
